FILE: sv/rcsm_pkg.sv
// ----------------------------------------------------------------------------
// rcsm_pkg
// Shared constants, register indexes and the heading wrap helper for the
// RC stick setpoint mapper.
// ----------------------------------------------------------------------------
package rcsm_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHoldMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThrustMin = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThrustMax = 2'd2;

  // Stick geometry in microseconds
  localparam logic [10:0] StickLo   = 11'd1000;
  localparam logic [10:0] StickHi   = 11'd2000;
  localparam logic [10:0] RollLo    = 11'd1043;
  localparam logic [10:0] RollHi    = 11'd1970;
  localparam logic [10:0] BandUp    = 11'd1530;
  localparam logic [10:0] BandDown  = 11'd1470;
  localparam logic [10:0] YawCwUs   = 11'd1525;
  localparam logic [10:0] YawCcwUs  = 11'd1450;
  localparam logic [10:0] ThrArmUs  = 11'd1100;

  // Yaw rate command
  localparam logic signed [11:0] StickMidS = 12'sd1500;
  localparam logic signed [11:0] YawBand   = 12'sd30;
  localparam logic signed [11:0] YawSpan   = 12'sd500;
  localparam logic signed [18:0] YawGain   = 19'sd400;
  localparam logic [15:0]        YawStepMs = 16'd200;

  // Attitude scale factors (numerators over the reduced divisors)
  localparam logic [22:0] RollPosGain   = 23'd375;    // 15000/440 = 375/11
  localparam logic [22:0] RollNegGain   = 23'd15000;  // over 427
  localparam logic [19:0] PitchGain     = 20'd1500;   // 15000/470 = 1500/47

  // Reciprocals for exact truncating division of bounded numerators
  localparam logic [26:0] ThrRecip      = 27'd68719477; // /1000, n=26
  localparam int unsigned ThrShift      = 36;
  localparam logic [23:0] RollPosRecip  = 24'd381301;   // /11, n=18
  localparam int unsigned RollPosShift  = 22;
  localparam logic [23:0] RollNegRecip  = 24'd10058472; // /427, n=23
  localparam int unsigned RollNegShift  = 32;
  localparam logic [20:0] PitchRecip    = 21'd1427849;  // /47, n=20
  localparam int unsigned PitchShift    = 26;

  // Heading wrap boundaries
  localparam logic signed [21:0] HalfTurn   = 22'sd180000;
  localparam logic signed [21:0] FullTurn   = 22'sd360000;
  localparam logic signed [21:0] ThreeHalf  = 22'sd540000;
  localparam logic signed [21:0] TwoTurns   = 22'sd720000;

  // Payload of a beat between the front and back halves of the datapath
  typedef struct packed {
    logic [25:0]        thr_num;
    logic               thr_neg;
    logic [22:0]        roll_num;
    logic               roll_neg;
    logic [19:0]        pitch_num;
    logic               pitch_neg;
    logic signed [18:0] yaw_a;
    logic signed [18:0] yaw_b;
    logic               yaw_wrap;
  } mid_beat_t;

  // Wrap a sum within two turns of zero onto [-180000, 180000)
  function automatic logic signed [18:0] wrap_turn(input logic signed [21:0] x);
    logic signed [21:0] r;
    priority if (x >= ThreeHalf) begin
      r = x - TwoTurns;
    end else if (x >= HalfTurn) begin
      r = x - FullTurn;
    end else if (x >= -HalfTurn) begin
      r = x;
    end else if (x >= -ThreeHalf) begin
      r = x + FullTurn;
    end else begin
      r = x + TwoTurns;
    end
    return r[18:0];
  endfunction

endpackage

FILE: sv/rc_stick_setpoint_mapper.sv
// ----------------------------------------------------------------------------
// rc_stick_setpoint_mapper
// Maps four RC pulse widths, the heading and the tick length to thrust,
// roll, pitch and yaw setpoints, one beat per cycle while the result side keeps taking.
// ----------------------------------------------------------------------------
// Three register stages (input, mid, result) with one beat in each; a beat
// is accepted every cycle while the result side keeps taking, and each result
// passes from the input register through the mid register to the result
// register. The mid stage splits each thrust and attitude numerator multiply
// from the reciprocal multiply that divides it, and the heading-hold offset
// and last heading are updated as a beat leaves the input stage. Configuration
// writes are always taken (cfg_ready_o is tied high).
module rc_stick_setpoint_mapper
  import rcsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [10:0]         throttle_us_i,
  input  logic [10:0]         roll_us_i,
  input  logic [10:0]         pitch_us_i,
  input  logic [10:0]         yaw_us_i,
  input  logic signed [18:0]  heading_mdeg_i,
  input  logic [7:0]          tick_ms_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         thrust_o,
  output logic signed [14:0]  roll_ref_mdeg_o,
  output logic signed [14:0]  pitch_ref_mdeg_o,
  output logic signed [18:0]  yaw_ref_o
);

  // Configuration registers
  logic        hold_mode_q;
  logic [15:0] thrust_min_q, thrust_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_mode_q  <= 1'b0;
      thrust_min_q <= 16'd0;
      thrust_max_q <= 16'hFFFF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHoldMode:  hold_mode_q  <= cfg_data_i[0];
        CfgThrustMin: thrust_min_q <= cfg_data_i;
        CfgThrustMax: thrust_max_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Stage handshakes
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic in_accept, s1_move, s2_move;

  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_accept  = in_valid_i && s1_ready;
  assign s1_move    = s1_valid_q && s2_ready;
  assign s2_move    = s2_valid_q && s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q  <= in_valid_i;
      if (s2_ready) s2_valid_q  <= s1_valid_q;
      if (s3_ready) out_valid_q <= s2_valid_q;
    end
  end

  // Input register: capture the accepted beat
  logic               cmd_q;
  logic [10:0]        thr_q, rol_q, pit_q, yaw_q;
  logic signed [18:0] hdg_q;
  logic [7:0]         tick_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= cmd_i;
      thr_q  <= throttle_us_i;
      rol_q  <= roll_us_i;
      pit_q  <= pitch_us_i;
      yaw_q  <= yaw_us_i;
      hdg_q  <= heading_mdeg_i;
      tick_q <= tick_ms_i;
    end
  end

  // Front half: thrust product, attitude numerators, yaw terms
  mid_beat_t          mid_d, mid_q;
  logic [10:0]        thr_c, rol_c, pit_c;
  logic [9:0]         thr_ofs;
  logic signed [16:0] thr_diff;
  logic [15:0]        thr_mag;
  logic [8:0]         roll_x, pitch_x;
  logic               thr_armed;
  logic signed [11:0] yaw_e, yaw_ec;
  logic signed [18:0] rate_cmd;
  logic [15:0]        yaw_step;
  logic signed [21:0] step_s, off_sum;
  logic signed [18:0] yaw_offset_q, yaw_offset_d;
  logic signed [18:0] last_hdg_q, last_hdg_d;

  always_comb begin
    // thrust: clamp the stick, scale by the signed span
    priority if (thr_q < StickLo) thr_c = StickLo;
    else if (thr_q > StickHi)     thr_c = StickHi;
    else                          thr_c = thr_q;
    thr_ofs  = 10'(thr_c - StickLo);
    thr_diff = 17'(signed'({1'b0, thrust_max_q})) - 17'(signed'({1'b0, thrust_min_q}));
    mid_d.thr_neg = thr_diff[16];
    thr_mag  = mid_d.thr_neg ? 16'(-thr_diff) : thr_diff[15:0];
    mid_d.thr_num = 26'(thr_ofs) * 26'(thr_mag);

    // roll: deadband, own stick limits on each side
    rol_c  = rol_q;
    roll_x = 9'd0;
    mid_d.roll_neg = 1'b0;
    mid_d.roll_num = 23'd0;
    if (rol_q >= BandUp) begin
      rol_c  = (rol_q > RollHi) ? RollHi : rol_q;
      roll_x = 9'(rol_c - BandUp);
      mid_d.roll_num = 23'(roll_x) * RollPosGain;
    end else if (rol_q <= BandDown) begin
      rol_c  = (rol_q < RollLo) ? RollLo : rol_q;
      roll_x = 9'(BandDown - rol_c);
      mid_d.roll_neg = 1'b1;
      mid_d.roll_num = 23'(roll_x) * RollNegGain;
    end

    // pitch: deadband, inverted sense
    pit_c   = pit_q;
    pitch_x = 9'd0;
    mid_d.pitch_neg = 1'b0;
    if (pit_q >= BandUp) begin
      pit_c   = (pit_q > StickHi) ? StickHi : pit_q;
      pitch_x = 9'(pit_c - BandUp);
      mid_d.pitch_neg = 1'b1;
    end else if (pit_q <= BandDown) begin
      pit_c   = (pit_q < StickLo) ? StickLo : pit_q;
      pitch_x = 9'(BandDown - pit_c);
    end
    mid_d.pitch_num = 20'(pitch_x) * PitchGain;

    // yaw rate command
    thr_armed = thr_q > ThrArmUs;
    yaw_e = signed'({1'b0, yaw_q}) - StickMidS;
    priority if (yaw_e > YawSpan) yaw_ec = YawSpan;
    else if (yaw_e < -YawSpan)    yaw_ec = -YawSpan;
    else                          yaw_ec = yaw_e;
    if (!thr_armed || (yaw_e <= YawBand && yaw_e >= -YawBand)) begin
      rate_cmd = 19'sd0;
    end else begin
      rate_cmd = 19'(yaw_ec) * YawGain;
    end

    // heading hold: stick nudges the offset, heading change is taken out
    yaw_step = 16'(tick_q) * YawStepMs;
    step_s   = 22'sd0;
    if (thr_armed && yaw_q > YawCwUs)  step_s = 22'(signed'({1'b0, yaw_step}));
    if (thr_armed && yaw_q < YawCcwUs) step_s = -22'(signed'({1'b0, yaw_step}));
    off_sum = 22'(yaw_offset_q) + step_s - (22'(hdg_q) - 22'(last_hdg_q));

    // select yaw operands and next state
    yaw_offset_d = yaw_offset_q;
    last_hdg_d   = last_hdg_q;
    if (cmd_q) begin
      yaw_offset_d   = 19'sd0;
      last_hdg_d     = hdg_q;
      mid_d.yaw_a    = 19'sd0;
      mid_d.yaw_b    = hdg_q;
      mid_d.yaw_wrap = 1'b1;
    end else if (hold_mode_q) begin
      yaw_offset_d   = wrap_turn(off_sum);
      last_hdg_d     = hdg_q;
      mid_d.yaw_a    = yaw_offset_d;
      mid_d.yaw_b    = hdg_q;
      mid_d.yaw_wrap = 1'b1;
    end else begin
      mid_d.yaw_a    = rate_cmd;
      mid_d.yaw_b    = 19'sd0;
      mid_d.yaw_wrap = 1'b0;
    end
  end

  // Heading-hold state advances as each beat leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_offset_q <= 19'sd0;
      last_hdg_q   <= 19'sd0;
    end else if (s1_move) begin
      yaw_offset_q <= yaw_offset_d;
      last_hdg_q   <= last_hdg_d;
    end
  end

  // Mid register
  always_ff @(posedge clk_i) begin
    if (s1_move) mid_q <= mid_d;
  end

  // Back half: reciprocal divides, signs, heading wrap
  logic [52:0]        thr_prod;
  logic [15:0]        thr_quo, thrust_d;
  logic [46:0]        roll_prod;
  logic [13:0]        roll_quo;
  logic [40:0]        pitch_prod;
  logic [13:0]        pitch_quo;
  logic signed [14:0] roll_d, pitch_d;
  logic signed [21:0] yaw_sum;
  logic signed [18:0] yaw_d;

  always_comb begin
    thr_prod = 53'(mid_q.thr_num) * 53'(ThrRecip);
    thr_quo  = 16'(thr_prod >> ThrShift);
    thrust_d = mid_q.thr_neg ? thrust_min_q - thr_quo : thrust_min_q + thr_quo;

    roll_prod = 47'(mid_q.roll_num) *
                47'(mid_q.roll_neg ? RollNegRecip : RollPosRecip);
    roll_quo  = mid_q.roll_neg ? 14'(roll_prod >> RollNegShift)
                               : 14'(roll_prod >> RollPosShift);
    roll_d    = mid_q.roll_neg ? -15'(roll_quo) : 15'(roll_quo);

    pitch_prod = 41'(mid_q.pitch_num) * 41'(PitchRecip);
    pitch_quo  = 14'(pitch_prod >> PitchShift);
    pitch_d    = mid_q.pitch_neg ? -15'(pitch_quo) : 15'(pitch_quo);

    yaw_sum = 22'(mid_q.yaw_a) + 22'(mid_q.yaw_b);
    yaw_d   = mid_q.yaw_wrap ? wrap_turn(yaw_sum) : yaw_sum[18:0];
  end

  // Result register
  logic [15:0]        thrust_q;
  logic signed [14:0] roll_q, pitch_q;
  logic signed [18:0] yaw_ref_q;

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      thrust_q  <= thrust_d;
      roll_q    <= roll_d;
      pitch_q   <= pitch_d;
      yaw_ref_q <= yaw_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign thrust_o         = thrust_q;
  assign roll_ref_mdeg_o  = roll_q;
  assign pitch_ref_mdeg_o = pitch_q;
  assign yaw_ref_o        = yaw_ref_q;

  // Checks
  a_offset_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_offset_q >= -19'sd180000 && yaw_offset_q < 19'sd180000)
    else $error("heading offset left its wrapped range");

  a_attitude_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_ref_mdeg_o <= 15'sd15000 && roll_ref_mdeg_o >= -15'sd15000 &&
                     pitch_ref_mdeg_o <= 15'sd15000 && pitch_ref_mdeg_o >= -15'sd15000))
    else $error("attitude setpoint outside +-15 degrees");

  a_thrust_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((thrust_o >= thrust_min_q && thrust_o <= thrust_max_q) ||
                     (thrust_o >= thrust_max_q && thrust_o <= thrust_min_q)))
    else $error("thrust outside configured range");

  a_state_only_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_move |=> $stable(yaw_offset_q) && $stable(last_hdg_q))
    else $error("heading state changed without a beat leaving the input stage");

endmodule
